// ===== src/plcm_pkg.sv =====
// Shared types, constants and color tables for the piecewise-linear color map.
// Used by every module of the block; depends on nothing.
package plcm_pkg;

	// Fixed-point format and field widths
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int CH_W      = 8;
	localparam int NCH       = 3;
	localparam int IDX_W     = 2;

	// Channel positions inside an rgb_t
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// Rainbow geometry: five segments, four inner stops
	localparam int RAINBOW_SEG = 5;
	localparam int NUM_INNER   = RAINBOW_SEG - 1;
	localparam int SEG_W       = 3;
	localparam int INNER_W     = $clog2(NUM_INNER);
	localparam logic [SEG_W-1:0] SEG_FIRST        = SEG_W'(0);
	localparam logic [SEG_W-1:0] SEG_TWO_LAST     = SEG_W'(1);
	localparam logic [SEG_W-1:0] SEG_RAINBOW_LAST = SEG_W'(RAINBOW_SEG);

	// Blend numerator is at most 255 * span, the quotient fits one channel
	localparam int NUM_W = DATA_W + CH_W;
	localparam int QUO_W = CH_W;

	// Stop sequencer: span / 5 as (span * RECIP_5) >> DIV_SHIFT, exact for 32-bit spans
	localparam int CNT_W     = INNER_W;
	localparam int REM_W     = 3;
	localparam int DIV_STEPS = 2;
	localparam int DIV_SHIFT = 34;
	localparam logic [DATA_W-1:0] RECIP_5    = 32'hCCCC_CCCD;
	localparam logic [DATA_W-1:0] HIGH_RESET = DATA_W'(1) << FRAC_BITS;

	typedef enum logic [IDX_W-1:0] {
		REG_RANGE_LOW    = 2'd0,
		REG_RANGE_HIGH   = 2'd1,
		REG_COLOR_SCHEME = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEQ_LOAD,
		SEQ_DIV,
		SEQ_STOP,
		SEQ_IDLE
	} seq_state_t;

	typedef logic [NCH-1:0][CH_W-1:0]  rgb_t;
	typedef logic [NCH-1:0][NUM_W-1:0] num_t;

	// Configuration view handed to the datapath
	typedef struct packed {
		logic [DATA_W-1:0]                 lo;
		logic [DATA_W-1:0]                 hi;
		logic [NUM_INNER-1:0][DATA_W-1:0]  stop;
		logic                              rainbow;
		logic                              busy;
	} cfg_t;

	// Color of stop idx for the selected scheme
	function automatic rgb_t stop_color(input logic rainbow, input logic [SEG_W-1:0] idx);
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		rgb_t            c;
		if (!rainbow) begin
			if (idx == SEG_FIRST) begin
				r = 8'd0;   g = 8'd0;   b = 8'd255;
			end else begin
				r = 8'd255; g = 8'd0;   b = 8'd0;
			end
		end else begin
			case (idx)
				3'd0: begin r = 8'd153; g = 8'd102; b = 8'd255; end
				3'd1: begin r = 8'd0;   g = 8'd0;   b = 8'd255; end
				3'd2: begin r = 8'd0;   g = 8'd255; b = 8'd0;   end
				3'd3: begin r = 8'd255; g = 8'd255; b = 8'd0;   end
				3'd4: begin r = 8'd255; g = 8'd102; b = 8'd0;   end
				default: begin r = 8'd255; g = 8'd0; b = 8'd0; end
			endcase
		end
		c[CH_RED]   = r;
		c[CH_GREEN] = g;
		c[CH_BLUE]  = b;
		return c;
	endfunction

	// Carry into inner stop k (k = idx + 1): floor(k*r/5) - floor((k-1)*r/5)
	function automatic logic stop_inc(input logic [INNER_W-1:0] idx,
	                                  input logic [REM_W-1:0] r);
		logic [NUM_INNER-1:0] mask;
		case (r)
			3'd2:    mask = 4'b0100;
			3'd3:    mask = 4'b1010;
			3'd4:    mask = 4'b1110;
			default: mask = 4'b0000;
		endcase
		return mask[idx];
	endfunction

endpackage

// ===== src/plcm_cfg.sv =====
// Configuration registers and the inner-stop sequencer.
// Divides the span by five with a reciprocal multiply and builds the four rainbow stops;
// uses plcm_pkg.
module plcm_cfg import plcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output cfg_t              cfg
);

	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] hi_q;
	logic              scheme_q;
	seq_state_t        state_q;
	seq_state_t        state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [DATA_W-1:0] quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [DATA_W-1:0] run_q;
	logic [DATA_W-1:0] stop_q [NUM_INNER];

	logic                wr_lo;
	logic                wr_hi;
	logic                wr_scheme;
	logic [2*DATA_W-1:0] prod;
	logic [DATA_W-1:0]   quo_div;
	logic [DATA_W-1:0]   run_next;

	localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(DIV_STEPS - 1);
	localparam logic [INNER_W-1:0] STOP_LAST = INNER_W'(NUM_INNER - 1);

	// Write decode
	assign wr_lo     = cfg_valid && (cfg_index == REG_RANGE_LOW);
	assign wr_hi     = cfg_valid && (cfg_index == REG_RANGE_HIGH);
	assign wr_scheme = cfg_valid && (cfg_index == REG_COLOR_SCHEME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q     <= '0;
			hi_q     <= HIGH_RESET;
			scheme_q <= 1'b0;
		end else begin
			if (wr_lo)     lo_q     <= cfg_data;
			if (wr_hi)     hi_q     <= cfg_data;
			if (wr_scheme) scheme_q <= cfg_data[0];
		end
	end

	// span / 5 by reciprocal multiply
	assign prod    = (2*DATA_W)'(quo_q) * (2*DATA_W)'(RECIP_5);
	assign quo_div = DATA_W'(prod >> DIV_SHIFT);

	// Next inner stop: previous stop + span/5 + carry from the remainder
	assign run_next = run_q + quo_q + DATA_W'(stop_inc(cnt_q[INNER_W-1:0], rem_q));

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			SEQ_LOAD: begin
				state_d = SEQ_DIV;
				cnt_d   = '0;
			end
			SEQ_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = SEQ_STOP;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			SEQ_STOP: begin
				if (cnt_q[INNER_W-1:0] == STOP_LAST) begin
					state_d = SEQ_IDLE;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			SEQ_IDLE: begin
				state_d = SEQ_IDLE;
			end
			default: begin
				state_d = SEQ_LOAD;
			end
		endcase
		// A new range restarts the stop computation
		if (wr_lo || wr_hi) begin
			state_d = SEQ_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			SEQ_LOAD: begin
				quo_q <= hi_q - lo_q;
				rem_q <= '0;
				run_q <= lo_q;
			end
			SEQ_DIV: begin
				if (cnt_q == '0) begin
					quo_q <= quo_div;
					rem_q <= quo_q[REM_W-1:0];
				end else begin
					// remainder = span - 5 * quotient, low bits only (q*5 = q + q*4)
					rem_q <= rem_q - quo_q[REM_W-1:0] - (quo_q[REM_W-1:0] << 2);
				end
			end
			SEQ_STOP: begin
				run_q                       <= run_next;
				stop_q[cnt_q[INNER_W-1:0]] <= run_next;
			end
			default: begin
			end
		endcase
	end

	// Configuration view
	always_comb begin
		cfg.lo      = lo_q;
		cfg.hi      = hi_q;
		for (int k = 0; k < NUM_INNER; k++) begin
			cfg.stop[k] = stop_q[k];
		end
		cfg.rainbow = scheme_q;
		cfg.busy    = (state_q != SEQ_IDLE);
	end

endmodule

// ===== src/plcm_front.sv =====
// Front pipeline: segment search, blend weights, products and numerator sum.
// Four stages with per-stage valid and bubble-collapsing stall; uses plcm_pkg.
module plcm_front import plcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] sample_value,
	output logic              dn_valid,
	input  logic              dn_ready,
	output num_t              dn_num,
	output logic [DATA_W-1:0] dn_den
);

	logic en1, en2, en3, en4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// Stage 1 registers
	logic [DATA_W-1:0] v_s1;
	logic              lelo_s1;
	logic              gehi_s1;
	logic [SEG_W-1:0]  seg_s1;

	// Stage 2 registers
	rgb_t              c0_s2;
	rgb_t              c1_s2;
	logic [DATA_W-1:0] w0_s2;
	logic [DATA_W-1:0] w1_s2;
	logic [DATA_W-1:0] den_s2;

	// Stage 3 and 4 registers
	num_t              p0_s3;
	num_t              p1_s3;
	logic [DATA_W-1:0] den_s3;
	num_t              num_s4;
	logic [DATA_W-1:0] den_s4;

	logic [NUM_INNER-1:0] ge_stop;
	logic [SEG_W-1:0]     seg_c;
	logic [DATA_W-1:0]    s0_c;
	logic [DATA_W-1:0]    s1_c;
	rgb_t                 c0_c;
	rgb_t                 c1_c;
	logic [DATA_W-1:0]    w0_c;
	logic [DATA_W-1:0]    w1_c;
	logic [DATA_W-1:0]    den_c;
	num_t                 p0_c;
	num_t                 p1_c;

	// Stage advance: a stage moves when empty or when the next one moves
	assign en4      = !vld_s4 || dn_ready;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	// Stage 1: range tests and segment = number of inner stops at or below the value
	always_comb begin
		seg_c = '0;
		for (int k = 0; k < NUM_INNER; k++) begin
			ge_stop[k] = $signed(sample_value) >= $signed(cfg.stop[k]);
			seg_c      = seg_c + SEG_W'(ge_stop[k]);
		end
		if (!cfg.rainbow) begin
			seg_c = SEG_FIRST;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			v_s1    <= sample_value;
			lelo_s1 <= $signed(sample_value) <= $signed(cfg.lo);
			gehi_s1 <= $signed(sample_value) >= $signed(cfg.hi);
			seg_s1  <= seg_c;
		end
	end

	// Stage 2: bounding stops, weights and end colors
	always_comb begin
		case (seg_s1)
			3'd1:    s0_c = cfg.stop[0];
			3'd2:    s0_c = cfg.stop[1];
			3'd3:    s0_c = cfg.stop[2];
			3'd4:    s0_c = cfg.stop[3];
			default: s0_c = cfg.lo;
		endcase
		if (!cfg.rainbow) begin
			s1_c = cfg.hi;
		end else begin
			case (seg_s1)
				3'd0:    s1_c = cfg.stop[0];
				3'd1:    s1_c = cfg.stop[1];
				3'd2:    s1_c = cfg.stop[2];
				3'd3:    s1_c = cfg.stop[3];
				default: s1_c = cfg.hi;
			endcase
		end
		c0_c  = stop_color(cfg.rainbow, seg_s1);
		c1_c  = stop_color(cfg.rainbow, seg_s1 + SEG_W'(1));
		w0_c  = s1_c - v_s1;
		w1_c  = v_s1 - s0_c;
		den_c = s1_c - s0_c;
		// Clamped values pass one end color through unchanged
		if (lelo_s1 || gehi_s1) begin
			c0_c  = stop_color(cfg.rainbow, lelo_s1 ? SEG_FIRST :
			                   (cfg.rainbow ? SEG_RAINBOW_LAST : SEG_TWO_LAST));
			w0_c  = DATA_W'(1);
			w1_c  = '0;
			den_c = DATA_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			c0_s2  <= c0_c;
			c1_s2  <= c1_c;
			w0_s2  <= w0_c;
			w1_s2  <= w1_c;
			den_s2 <= den_c;
		end
	end

	// Stage 3: channel times weight products
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			p0_c[ch] = NUM_W'(c0_s2[ch]) * NUM_W'(w0_s2);
			p1_c[ch] = NUM_W'(c1_s2[ch]) * NUM_W'(w1_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			p0_s3  <= p0_c;
			p1_s3  <= p1_c;
			den_s3 <= den_s2;
		end
	end

	// Stage 4: numerator sum, bounded by 255 * den
	always_ff @(posedge clk) begin
		if (en4) begin
			for (int ch = 0; ch < NCH; ch++) begin
				num_s4[ch] <= p0_s3[ch] + p1_s3[ch];
			end
			den_s4 <= den_s3;
		end
	end

	assign dn_valid = vld_s4;
	assign dn_num   = num_s4;
	assign dn_den   = den_s4;

endmodule

// ===== src/plcm_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for all three channels.
// Quotient is known to fit in one channel width; uses plcm_pkg.
module plcm_div import plcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  num_t              up_num,
	input  logic [DATA_W-1:0] up_den,
	output logic              out_valid,
	input  logic              out_ready,
	output rgb_t              out_color
);

	localparam int LAST = QUO_W - 1;

	logic [QUO_W-1:0]  en;
	logic [QUO_W-1:0]  vld_s;
	rgb_t              quo_s [QUO_W];
	num_t              rem_s [LAST];
	logic [DATA_W-1:0] den_s [LAST];

	// Inputs seen by each stage
	logic [QUO_W-1:0]  pv;
	rgb_t              pquo [QUO_W];
	num_t              prem [QUO_W];
	logic [DATA_W-1:0] pden [QUO_W];

	assign up_ready = en[0];

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		localparam int BIT = QUO_W - 1 - j;

		logic [NUM_W-1:0] dsh;
		num_t             rem_c;
		rgb_t             quo_c;

		// Stage input selection
		if (j == 0) begin : g_first
			assign pv[j]   = up_valid;
			assign pquo[j] = '0;
			assign prem[j] = up_num;
			assign pden[j] = up_den;
		end else begin : g_next
			assign pv[j]   = vld_s[j-1];
			assign pquo[j] = quo_s[j-1];
			assign prem[j] = rem_s[j-1];
			assign pden[j] = den_s[j-1];
		end

		// Stall chain
		if (j == LAST) begin : g_en_last
			assign en[j] = !vld_s[j] || out_ready;
		end else begin : g_en_mid
			assign en[j] = !vld_s[j] || en[j+1];
		end

		// Trial subtract of the shifted divisor
		always_comb begin
			dsh   = NUM_W'(pden[j]) << BIT;
			quo_c = pquo[j];
			for (int ch = 0; ch < NCH; ch++) begin
				if (prem[j][ch] >= dsh) begin
					rem_c[ch]      = prem[j][ch] - dsh;
					quo_c[ch][BIT] = 1'b1;
				end else begin
					rem_c[ch]      = prem[j][ch];
					quo_c[ch][BIT] = 1'b0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en[j]) begin
				vld_s[j] <= pv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				quo_s[j] <= quo_c;
			end
		end

		// Remainder and divisor are not needed past the last bit
		if (j < LAST) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j] <= rem_c;
					den_s[j] <= pden[j];
				end
			end
		end
	end

	assign out_valid = vld_s[LAST];
	assign out_color = quo_s[LAST];

endmodule

// ===== src/piecewise_linear_colormap.sv =====
// 12 stages (4 front, 8 divider); a stalled output backs up stage by stage, bubbles collapse.
// Throughput: one request per cycle while the stop sequencer is idle.
// Reset clears all valids and loads range_low = 0, range_high = 1.0, blue-red scheme.
// After reset and after every write of range_low or range_high, the stop sequencer runs
// its load, two-step divide by five and four stop sums with in_ready low.
// Configuration writes are always taken. Top level; uses plcm_pkg, plcm_cfg, plcm_front, plcm_div.
module piecewise_linear_colormap import plcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] sample_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CH_W-1:0]   red_level,
	output logic [CH_W-1:0]   green_level,
	output logic [CH_W-1:0]   blue_level
);

	cfg_t              cfg;
	logic              front_ready;
	logic              mid_valid;
	logic              mid_ready;
	num_t              mid_num;
	logic [DATA_W-1:0] mid_den;
	rgb_t              color;

	assign cfg_ready = 1'b1;

	plcm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Requests wait while the stops are being rebuilt
	assign in_ready = front_ready && !cfg.busy;

	plcm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid && !cfg.busy),
		.in_ready     (front_ready),
		.sample_value (sample_value),
		.dn_valid     (mid_valid),
		.dn_ready     (mid_ready),
		.dn_num       (mid_num),
		.dn_den       (mid_den)
	);

	plcm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (mid_valid),
		.up_ready  (mid_ready),
		.up_num    (mid_num),
		.up_den    (mid_den),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_color (color)
	);

	assign red_level   = color[CH_RED];
	assign green_level = color[CH_GREEN];
	assign blue_level  = color[CH_BLUE];

endmodule

// ===== verif/piecewise_linear_colormap_tb.sv =====
// Self-checking testbench for piecewise_linear_colormap: directed table, then random requests
// under varying idle and stall patterns, checked against typed-in or in-bench predicted colors.
// Depends on plcm_pkg and the piecewise_linear_colormap RTL only.
`timescale 1ns / 1ps

module piecewise_linear_colormap_tb;
	import plcm_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} color_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

	typedef struct packed {
		row_kind_e         kind;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;
		logic              known;
		color_t            want;
	} stim_row_t;

	// Stop colors
	localparam color_t VIOLET   = {8'd153, 8'd102, 8'd255};
	localparam color_t BLUE     = {8'd0, 8'd0, 8'd255};
	localparam color_t GREEN    = {8'd0, 8'd255, 8'd0};
	localparam color_t YELLOW   = {8'd255, 8'd255, 8'd0};
	localparam color_t ORANGE   = {8'd255, 8'd102, 8'd0};
	localparam color_t RED      = {8'd255, 8'd0, 8'd0};
	localparam color_t NO_COLOR = '0;

	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [IDX_W-1:0] NO_REG     = '0;
	localparam logic [DATA_W-1:0] VAL_MIN   = 32'h8000_0000;
	localparam logic [DATA_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 30;
	localparam int NUM_SETTINGS   = 6;

	// Directed requests; expected colors typed in where they are obvious
	localparam int NUM_ROWS = 34;
	localparam stim_row_t DIRECTED [NUM_ROWS] = '{
		// reset settings: 0 .. 1.0, blue-red
		'{ROW_SAMPLE, NO_REG, 32'h0000_0000, 1'b1, BLUE},
		'{ROW_SAMPLE, NO_REG, VAL_MIN,       1'b1, BLUE},
		'{ROW_SAMPLE, NO_REG, VAL_MAX,       1'b1, RED},
		'{ROW_SAMPLE, NO_REG, 32'h0001_0000, 1'b1, RED},
		'{ROW_SAMPLE, NO_REG, 32'h0000_8000, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'h0000_0001, 1'b0, NO_COLOR},
		// rainbow; only bit 0 of the data counts
		'{ROW_WRITE, REG_COLOR_SCHEME, 32'hFFFF_FFFF, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'h0000_0000, 1'b1, VIOLET},
		'{ROW_SAMPLE, NO_REG, 32'h0001_0000, 1'b1, RED},
		// exactly on each inner stop
		'{ROW_SAMPLE, NO_REG, 32'h0000_3333, 1'b1, BLUE},
		'{ROW_SAMPLE, NO_REG, 32'h0000_6666, 1'b1, GREEN},
		'{ROW_SAMPLE, NO_REG, 32'h0000_9999, 1'b1, YELLOW},
		'{ROW_SAMPLE, NO_REG, 32'h0000_CCCC, 1'b1, ORANGE},
		'{ROW_SAMPLE, NO_REG, 32'h0000_FFFF, 1'b0, NO_COLOR},
		// write to an unused index must change nothing
		'{ROW_WRITE, REG_UNUSED, VAL_MIN, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'h0000_3333, 1'b1, BLUE},
		// full 32-bit span
		'{ROW_WRITE, REG_RANGE_LOW,  VAL_MIN, 1'b0, NO_COLOR},
		'{ROW_WRITE, REG_RANGE_HIGH, VAL_MAX, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'h0000_0000, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'h8000_0001, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'h7FFF_FFFE, 1'b0, NO_COLOR},
		// empty range: low test wins
		'{ROW_WRITE, REG_RANGE_LOW,  32'd100, 1'b0, NO_COLOR},
		'{ROW_WRITE, REG_RANGE_HIGH, 32'd100, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'd100, 1'b1, VIOLET},
		'{ROW_SAMPLE, NO_REG, 32'd101, 1'b1, RED},
		// inverted range
		'{ROW_WRITE, REG_RANGE_HIGH, 32'd50, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'd60,  1'b1, VIOLET},
		'{ROW_SAMPLE, NO_REG, 32'd200, 1'b1, RED},
		// narrow range, coinciding stops
		'{ROW_WRITE, REG_RANGE_LOW,  32'd0, 1'b0, NO_COLOR},
		'{ROW_WRITE, REG_RANGE_HIGH, 32'd3, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'd1, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'd2, 1'b0, NO_COLOR},
		'{ROW_WRITE, REG_COLOR_SCHEME, 32'h0000_0000, 1'b0, NO_COLOR},
		'{ROW_SAMPLE, NO_REG, 32'd2, 1'b0, NO_COLOR}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [DATA_W-1:0] sample_value;
	logic              out_valid;
	logic              out_ready;
	logic [CH_W-1:0]   red_level;
	logic [CH_W-1:0]   green_level;
	logic [CH_W-1:0]   blue_level;

	// Predictor copy of the configuration
	logic [DATA_W-1:0] low_q;
	logic [DATA_W-1:0] high_q;
	logic              rainbow_q;

	color_t pending_colors[$];
	int     errors       = 0;
	int     tx_idle_pct  = 0;
	int     rx_idle_pct  = 0;
	int     stall_asks   = 0;
	int     stall_served = 0;
	int     hold_left    = 0;
	int     quiet_cycles = 0;

	piecewise_linear_colormap uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic color_t stop_rgb(input logic rainbow, input int idx);
		if (!rainbow)
			return (idx == 0) ? BLUE : RED;
		case (idx)
			0: return VIOLET;
			1: return BLUE;
			2: return GREEN;
			3: return YELLOW;
			4: return ORANGE;
			default: return RED;
		endcase
	endfunction

	// floor((c0 * w0 + c1 * w1) / den) for one channel
	function automatic logic [CH_W-1:0] blend_level(input logic [CH_W-1:0] c0,
	                                                input logic [CH_W-1:0] c1,
	                                                input longint w0, input longint w1,
	                                                input longint den);
		return CH_W'((longint'(c0) * w0 + longint'(c1) * w1) / den);
	endfunction

	// Color the block should return for one sample under the current settings
	function automatic color_t expected_color(input logic [DATA_W-1:0] v);
		longint sv;
		longint lo;
		longint hi;
		longint span;
		longint s0;
		longint s1;
		int     nseg;
		int     seg;
		int     k;
		color_t c0;
		color_t c1;
		color_t res;
		sv   = longint'($signed(v));
		lo   = longint'($signed(low_q));
		hi   = longint'($signed(high_q));
		nseg = rainbow_q ? RAINBOW_SEG : 1;
		if (sv <= lo)
			return stop_rgb(rainbow_q, 0);
		if (sv >= hi)
			return stop_rgb(rainbow_q, nseg);
		span = hi - lo;
		seg  = 0;
		// last stop at or below the value; zero-width segments drop out
		for (k = 1; k < nseg; k++)
			if (lo + (k * span) / nseg <= sv)
				seg = k;
		s0 = lo + (seg * span) / nseg;
		s1 = (seg + 1 == nseg) ? hi : lo + ((seg + 1) * span) / nseg;
		c0 = stop_rgb(rainbow_q, seg);
		c1 = stop_rgb(rainbow_q, seg + 1);
		res.red   = blend_level(c0.red,   c1.red,   s1 - sv, sv - s0, s1 - s0);
		res.green = blend_level(c0.green, c1.green, s1 - sv, sv - s0, s1 - s0);
		res.blue  = blend_level(c0.blue,  c1.blue,  s1 - sv, sv - s0, s1 - s0);
		return res;
	endfunction

	// Random sample aimed mostly inside the range, at stops and at the edges
	function automatic logic [DATA_W-1:0] pick_sample();
		longint lo;
		longint hi;
		longint span;
		longint x;
		int     pick;
		lo   = longint'($signed(low_q));
		hi   = longint'($signed(high_q));
		span = hi - lo;
		pick = $urandom_range(99);
		x    = longint'($signed($urandom));
		if (span > 0 && pick < 50)
			x = lo + longint'({32'b0, $urandom}) % (span + 1);
		else if (span > 0 && pick < 75)
			x = lo + (int'($urandom_range(RAINBOW_SEG)) * span) / RAINBOW_SEG
				+ int'($urandom_range(2)) - 1;
		else if (pick < 85)
			x = ($urandom_range(1) ? lo : hi) + int'($urandom_range(2)) - 1;
		else if (pick < 92)
			x = $urandom_range(1) ? longint'($signed(VAL_MIN)) : longint'($signed(VAL_MAX));
		return DATA_W'(x);
	endfunction

	// Drop the request line and wait until every result has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RANGE_LOW:    low_q     = data;
			REG_RANGE_HIGH:   high_q    = data;
			REG_COLOR_SCHEME: rainbow_q = data[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One sample request; valid stays up after acceptance for back-to-back requests
	task automatic offer_sample(input logic [DATA_W-1:0] v, input logic known, input color_t want);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid     <= 1'b1;
		sample_value <= v;
		do @(posedge clk); while (!in_ready);
		pending_colors.push_back(known ? want : expected_color(v));
	endtask

	// New random range and scheme; extremes, narrow, empty and inverted ranges included
	task automatic random_settings();
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		longint            base;
		case ($urandom_range(5))
			0: begin
				lo = VAL_MIN;
				hi = VAL_MAX;
			end
			1: begin
				base = longint'($urandom_range(1 << 24)) - (1 << 23);
				lo   = DATA_W'(base);
				hi   = DATA_W'(base + longint'($urandom_range(1 << 24, 1)));
			end
			2: begin
				lo = $urandom;
				hi = lo + $urandom_range(12);
			end
			3: begin
				lo = $urandom;
				hi = lo - $urandom_range(1000, 1);
			end
			4: begin
				lo = $urandom;
				hi = $urandom;
			end
			default: begin
				lo = $urandom_range(1) ? VAL_MIN : $urandom;
				hi = (lo == VAL_MIN) ? $urandom : VAL_MAX;
			end
		endcase
		if ($urandom_range(1)) begin
			write_reg(REG_RANGE_LOW, lo);
			write_reg(REG_RANGE_HIGH, hi);
		end else begin
			write_reg(REG_RANGE_HIGH, hi);
			write_reg(REG_RANGE_LOW, lo);
		end
		write_reg(REG_COLOR_SCHEME, $urandom);
		if ($urandom_range(3) == 0)
			write_reg(REG_UNUSED, $urandom);
	endtask

	task automatic check_level(input string name, input logic [CH_W-1:0] want,
	                           input logic [CH_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Result side: random or held-off ready, check each accepted result
	initial begin
		color_t want;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_colors.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %0d %0d %0d",
						$time, red_level, green_level, blue_level);
				end else begin
					want = pending_colors.pop_front();
					check_level("red_level",   want.red,   red_level);
					check_level("green_level", want.green, green_level);
					check_level("blue_level",  want.blue,  blue_level);
				end
			end
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_asks != stall_served) begin
				out_ready    <= 1'b0;
				hold_left    = LONG_HOLD;
				stall_served = stall_asks;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Watchdog: too long without any handshake ends the run
	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Request side and sequencing
	initial begin
		int tx_pct [3];
		int rx_pct [3];
		int phase;
		int set;
		int n;
		int count;
		tx_pct = '{36, 80, 0};
		rx_pct = '{80, 36, 0};
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		sample_value <= '0;
		low_q     = '0;
		high_q    = HIGH_RESET;
		rainbow_q = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = tx_pct[0];
		rx_idle_pct = rx_pct[0];
		for (n = 0; n < NUM_ROWS; n++) begin
			if (DIRECTED[n].kind == ROW_WRITE)
				write_reg(DIRECTED[n].idx, DIRECTED[n].data);
			else
				offer_sample(DIRECTED[n].data, DIRECTED[n].known, DIRECTED[n].want);
		end

		for (phase = 0; phase < 3; phase++) begin
			settle();
			tx_idle_pct = tx_pct[phase];
			rx_idle_pct = rx_pct[phase];
			for (set = 0; set < NUM_SETTINGS; set++) begin
				random_settings();
				// long receiver hold-off while requests keep coming
				if (phase == 2 && set == 0)
					stall_asks++;
				count = 70 + $urandom_range(20);
				for (n = 0; n < count; n++)
					offer_sample(pick_sample(), 1'b0, NO_COLOR);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
